// File: design/pes2ts_pkg.sv
// ----------------------------------------------------------------------------
// pes2ts_pkg
// Shared types, constants and byte helpers of the PES to TS packetizer.
// ----------------------------------------------------------------------------
package pes2ts_pkg;

  localparam logic [7:0] TS_PAYLOAD_BYTES = 8'd184;
  localparam logic [5:0] WORDS_PER_PACKET = 6'd47;
  localparam logic [7:0] PCR_FIELD_BYTES  = 8'd8;

  localparam logic [1:0] REG_PID       = 2'd0;
  localparam logic [1:0] REG_STREAM_ID = 2'd1;
  localparam logic [1:0] REG_SYNC_BYTE = 2'd2;
  localparam logic [1:0] REG_ZERO_LEN  = 2'd3;

  localparam logic [12:0] PID_RESET       = 13'd2000;
  localparam logic [7:0]  STREAM_ID_RESET = 8'hE0;
  localparam logic [7:0]  SYNC_BYTE_RESET = 8'h47;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HDR,
    ST_DATA,
    ST_FLUSH
  } pes2ts_state_t;

  typedef struct packed {
    logic       load;
    logic       put_hdr;
    logic       put_data;
    logic       flush;
    logic [7:0] idx;
  } pes2ts_cmd_t;

  typedef struct packed {
    logic drop;
    logic need_hdr;
    logic can_put;
    logic hdr_last;
    logic flush_done;
  } pes2ts_stat_t;

  // One byte of a 33-bit time stamp written without prefix nibbles.
  function automatic logic [7:0] stamp_byte(input logic [32:0] t, input logic [3:0] s);
    logic [7:0] b;
    b = 8'h00;
    case (s)
      4'd0:    b = {4'b0000, t[32:30], 1'b1};
      4'd1:    b = t[29:22];
      4'd2:    b = {t[21:15], 1'b1};
      4'd3:    b = t[14:7];
      4'd4:    b = {t[6:0], 1'b1};
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // One byte of the PCR field: base bits, then bit 0 on top, then extension.
  function automatic logic [7:0] pcr_byte(input logic [32:0] t, input logic [3:0] s);
    logic [7:0] b;
    b = 8'h00;
    case (s)
      4'd0:    b = t[32:25];
      4'd1:    b = t[24:17];
      4'd2:    b = t[16:9];
      4'd3:    b = t[8:1];
      4'd4:    b = {t[0], 7'b0};
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: design/pes_to_ts_packetizer_core.sv
// ----------------------------------------------------------------------------
// pes_to_ts_packetizer_core
// Elementary-stream bytes in, 188-byte transport packets out as 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one payload byte per transfer with frame start,
//   frame length, PTS/DTS and PCR request fields alongside.
//   Output channel (out_*): big-endian 32-bit words; out_packet_end marks the
//   47th word of a packet, out_last the last word caused by one input byte.
//   APB port: pid at 0x0, stream_id at 0x4, sync_byte at 0x8,
//   zero_pes_length at 0xC; write only while the block is idle.
// Steps:
//   A payload byte inside a packet passes the accept, pack and flush steps.
//   A byte that opens a packet first has its 4 to 187 header bytes packed,
//   one by one, by the single-byte header sequencer. Dropped bytes end at accept.
// Reset (rst_n low, synchronous): registers return to defaults, counters and
// the word packer clear, no frame is open.
// Receiver stall: one word waits in the output register and one in a pending
// register; the sequencer holds until the stall clears, so nothing is lost.
module pes_to_ts_packetizer_core
  import pes2ts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_start,
  input  logic [23:0] in_frame_length,
  input  logic [32:0] in_pts,
  input  logic [32:0] in_dts,
  input  logic        in_pcr_due,
  input  logic [32:0] in_pcr_base,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_word,
  output logic        out_packet_end,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [12:0]  pid_r;
  logic [7:0]   stream_id_r;
  logic [7:0]   sync_byte_r;
  logic         zero_len_r;
  logic         wr_en;
  pes2ts_cmd_t  cmd;
  pes2ts_stat_t stat;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register writes; the two low address bits are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pid_r       <= PID_RESET;
      stream_id_r <= STREAM_ID_RESET;
      sync_byte_r <= SYNC_BYTE_RESET;
      zero_len_r  <= 1'b1;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_PID:       pid_r       <= pwdata[12:0];
        REG_STREAM_ID: stream_id_r <= pwdata[7:0];
        REG_SYNC_BYTE: sync_byte_r <= pwdata[7:0];
        REG_ZERO_LEN:  zero_len_r  <= pwdata[0];
        default:       pid_r       <= pid_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_PID:       prdata = {19'd0, pid_r};
      REG_STREAM_ID: prdata = {24'd0, stream_id_r};
      REG_SYNC_BYTE: prdata = {24'd0, sync_byte_r};
      REG_ZERO_LEN:  prdata = {31'd0, zero_len_r};
      default:       prdata = 32'd0;
    endcase
  end

  pes2ts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pes2ts_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .pid             (pid_r),
    .stream_id       (stream_id_r),
    .sync_byte       (sync_byte_r),
    .zero_pes_length (zero_len_r),
    .in_data_byte    (in_data_byte),
    .in_frame_start  (in_frame_start),
    .in_frame_length (in_frame_length),
    .in_pts          (in_pts),
    .in_dts          (in_dts),
    .in_pcr_due      (in_pcr_due),
    .in_pcr_base     (in_pcr_base),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_word        (out_word),
    .out_packet_end  (out_packet_end),
    .out_last        (out_last)
  );

endmodule

// File: design/pes2ts_ctrl.sv
// ----------------------------------------------------------------------------
// pes2ts_ctrl
// Sequencer: accepts an item, walks the header bytes, the payload byte and
// the final flush of the pending word.
// ----------------------------------------------------------------------------
module pes2ts_ctrl
  import pes2ts_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  pes2ts_stat_t stat,
  output pes2ts_cmd_t  cmd
);

  pes2ts_state_t state_r, state_nxt;
  logic [7:0]    idx_r, idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= 8'd0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    in_ready     = 1'b0;
    cmd.load     = 1'b0;
    cmd.put_hdr  = 1'b0;
    cmd.put_data = 1'b0;
    cmd.flush    = 1'b0;
    cmd.idx      = idx_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        idx_nxt  = 8'd0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (!stat.drop) begin
            state_nxt = stat.need_hdr ? ST_HDR : ST_DATA;
          end
        end
      end
      ST_HDR: begin
        if (stat.can_put) begin
          cmd.put_hdr = 1'b1;
          idx_nxt     = idx_r + 8'd1;
          if (stat.hdr_last) begin
            state_nxt = ST_DATA;
          end
        end
      end
      ST_DATA: begin
        if (stat.can_put) begin
          cmd.put_data = 1'b1;
          state_nxt    = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        cmd.flush = 1'b1;
        if (stat.flush_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// File: design/pes2ts_dp.sv
// ----------------------------------------------------------------------------
// pes2ts_dp
// Datapath: frame and packet counters, header byte generation, byte to word
// packing, pending word and output register.
// ----------------------------------------------------------------------------
module pes2ts_dp
  import pes2ts_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  pes2ts_cmd_t  cmd,
  output pes2ts_stat_t stat,
  input  logic [12:0]  pid,
  input  logic [7:0]   stream_id,
  input  logic [7:0]   sync_byte,
  input  logic         zero_pes_length,
  input  logic [7:0]   in_data_byte,
  input  logic         in_frame_start,
  input  logic [23:0]  in_frame_length,
  input  logic [32:0]  in_pts,
  input  logic [32:0]  in_dts,
  input  logic         in_pcr_due,
  input  logic [32:0]  in_pcr_base,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [31:0]  out_word,
  output logic         out_packet_end,
  output logic         out_last
);

  // stream state
  logic [23:0] fbl_r;
  logic [7:0]  pbl_r;
  logic [3:0]  cc_r;
  logic [23:0] pw_r;
  logic [1:0]  fill_r;
  logic [5:0]  wip_r;
  // latched item
  logic [7:0]  data_r;
  logic [32:0] pts_r, dts_r, pcr_r;
  logic        pcr_due_r, first_r;
  // pending and output words
  logic        pend_v_r;
  logic [31:0] pend_word_r;
  logic        pend_end_r;
  logic        out_v_r;
  logic [31:0] out_word_r;
  logic        out_end_r, out_last_r;

  // header geometry
  logic        with_dts;
  logic [7:0]  hlen, pes_n, tsrem0, t8, pad8, padp, af, af_end, tsrem_fin, hdr_n;
  logic        pad_pos, padp_pos;
  logic [15:0] pes_len;
  logic [7:0]  j, p, s, hbyte, byte_in;
  logic        put, word_done, out_free, move_pend;
  logic [31:0] new_word;
  logic [5:0]  wip_inc;

  always_comb begin
    with_dts  = (pts_r != dts_r);
    hlen      = with_dts ? 8'd13 : 8'd8;
    pes_n     = first_r ? (hlen + 8'd6) : 8'd0;
    tsrem0    = TS_PAYLOAD_BYTES - pes_n;
    t8        = tsrem0 - PCR_FIELD_BYTES;
    pad_pos   = (fbl_r < {16'd0, tsrem0});
    padp_pos  = (fbl_r < {16'd0, t8});
    pad8      = tsrem0 - fbl_r[7:0];
    padp      = padp_pos ? (t8 - fbl_r[7:0]) : 8'd0;
    if (pcr_due_r) begin
      af        = PCR_FIELD_BYTES + padp;
      tsrem_fin = t8 - padp;
    end else if (pad_pos) begin
      af        = pad8;
      tsrem_fin = tsrem0 - pad8;
    end else begin
      af        = 8'd0;
      tsrem_fin = tsrem0;
    end
    af_end  = 8'd4 + af;
    hdr_n   = af_end + pes_n;
    pes_len = zero_pes_length ? 16'd0 : (fbl_r[15:0] + {8'd0, hlen});
  end

  // header byte at position cmd.idx
  always_comb begin
    j     = cmd.idx - 8'd4;
    p     = cmd.idx - af_end;
    s     = p - 8'd9;
    hbyte = 8'h00;
    if (cmd.idx == 8'd0) begin
      hbyte = sync_byte;
    end else if (cmd.idx == 8'd1) begin
      hbyte = {1'b0, first_r, 1'b0, pid[12:8]};
    end else if (cmd.idx == 8'd2) begin
      hbyte = pid[7:0];
    end else if (cmd.idx == 8'd3) begin
      hbyte = (pcr_due_r || pad_pos) ? {4'h3, cc_r} : {4'h1, cc_r};
    end else if (cmd.idx < af_end) begin
      if (pcr_due_r) begin
        if (j == 8'd0) hbyte = 8'd7 + padp;
        else if (j == 8'd1) hbyte = 8'h10;
        else if (j < 8'd8) hbyte = pcr_byte(pcr_r, j[3:0] - 4'd2);
        else hbyte = 8'hFF;
      end else begin
        hbyte = (j == 8'd0) ? (pad8 - 8'd1) : 8'h00;
      end
    end else begin
      case (p)
        8'd0, 8'd1: hbyte = 8'h00;
        8'd2:       hbyte = 8'h01;
        8'd3:       hbyte = stream_id;
        8'd4:       hbyte = pes_len[15:8];
        8'd5:       hbyte = pes_len[7:0];
        8'd6:       hbyte = 8'h80;
        8'd7:       hbyte = with_dts ? 8'hC0 : 8'h80;
        8'd8:       hbyte = hlen - 8'd3;
        default: begin
          if (with_dts && s < 8'd5) hbyte = stamp_byte(pts_r, s[3:0]);
          else if (with_dts)        hbyte = stamp_byte(dts_r, s[3:0] - 4'd5);
          else                      hbyte = stamp_byte(dts_r, s[3:0]);
        end
      endcase
    end
  end

  always_comb begin
    put       = cmd.put_hdr || cmd.put_data;
    byte_in   = cmd.put_hdr ? hbyte : data_r;
    word_done = put && (fill_r == 2'd3);
    new_word  = {pw_r, byte_in};
    wip_inc   = wip_r + 6'd1;
    out_free  = !out_v_r || out_ready;
    move_pend = pend_v_r && (word_done || (cmd.flush && out_free));

    stat.drop       = (fbl_r == 24'd0) && (!in_frame_start || in_frame_length == 24'd0);
    stat.need_hdr   = (fbl_r == 24'd0) || (pbl_r == 8'd0);
    stat.can_put    = !((fill_r == 2'd3) && pend_v_r && !out_free);
    stat.hdr_last   = (cmd.idx == hdr_n - 8'd1);
    stat.flush_done = !pend_v_r || out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fbl_r    <= 24'd0;
      pbl_r    <= 8'd0;
      cc_r     <= 4'd0;
      pw_r     <= 24'd0;
      fill_r   <= 2'd0;
      wip_r    <= 6'd0;
      first_r  <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (cmd.load && !stat.drop) begin
        if (fbl_r == 24'd0) begin
          fbl_r   <= in_frame_length;
          pbl_r   <= 8'd0;
          first_r <= 1'b1;
        end else begin
          first_r <= 1'b0;
        end
      end
      if (cmd.put_hdr && stat.hdr_last) begin
        pbl_r <= tsrem_fin;
        cc_r  <= cc_r + 4'd1;
      end
      if (cmd.put_data) begin
        pbl_r <= pbl_r - 8'd1;
        fbl_r <= fbl_r - 24'd1;
      end
      // pack bytes into words
      if (put) begin
        if (word_done) begin
          pw_r   <= 24'd0;
          fill_r <= 2'd0;
          wip_r  <= (wip_inc >= WORDS_PER_PACKET) ? 6'd0 : wip_inc;
        end else begin
          pw_r   <= {pw_r[15:0], byte_in};
          fill_r <= fill_r + 2'd1;
        end
      end
      // hold the newest word back until it is known whether it is the last
      if (word_done) begin
        pend_v_r <= 1'b1;
      end else if (move_pend) begin
        pend_v_r <= 1'b0;
      end
      if (move_pend) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      data_r    <= in_data_byte;
      pcr_due_r <= in_pcr_due;
      pcr_r     <= in_pcr_base;
      if (fbl_r == 24'd0) begin
        pts_r <= in_pts;
        dts_r <= in_dts;
      end else begin
        pts_r <= in_pts;
        dts_r <= in_dts;
      end
    end
    if (word_done) begin
      pend_word_r <= new_word;
      pend_end_r  <= (wip_inc >= WORDS_PER_PACKET);
    end
    if (move_pend) begin
      out_word_r <= pend_word_r;
      out_end_r  <= pend_end_r;
      out_last_r <= cmd.flush;
    end
  end

  assign out_valid      = out_v_r;
  assign out_word       = out_word_r;
  assign out_packet_end = out_end_r;
  assign out_last       = out_last_r;

  a_wip_range: assert property (@(posedge clk) disable iff (!rst_n)
    wip_r < WORDS_PER_PACKET)
    else $error("word count ran past packet end");

  a_pend_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (word_done && pend_v_r) |=> (out_v_r && pend_v_r))
    else $error("pending word lost on new word");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.flush && stat.flush_done) |=> !pend_v_r)
    else $error("pending word kept after flush");

  a_frame_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.put_data |=> (fbl_r == $past(fbl_r) - 24'd1))
    else $error("frame byte count not advanced");

endmodule

// File: bench/pes_to_ts_packetizer_core_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pes_to_ts_packetizer_core_chk
// Watches the input, output and register ports of the packetizer. It predicts
// the transport words that each accepted payload byte causes and compares
// every output transfer, field by field, with the oldest predicted word.
// ----------------------------------------------------------------------------
module pes_to_ts_packetizer_core_chk
  import pes2ts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_start,
  input  logic [23:0] in_frame_length,
  input  logic [32:0] in_pts,
  input  logic [32:0] in_dts,
  input  logic        in_pcr_due,
  input  logic [32:0] in_pcr_base,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_word,
  input  logic        out_packet_end,
  input  logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          words_pending
);

  typedef struct {
    logic [31:0] word;
    logic        pkt_end;
    logic        last;
  } ts_word_t;

  ts_word_t ts_words_q[$];

  logic [12:0] pid_r;
  logic [7:0]  stream_id_r;
  logic [7:0]  sync_r;
  logic        zero_len_r;

  logic [23:0] frame_left;
  logic [7:0]  pkt_left;
  logic [3:0]  cont_cnt;
  logic [23:0] pack_bytes;
  logic [1:0]  pack_fill;
  logic [5:0]  pkt_words;
  int          words_made;

  // Pack one byte; every fourth byte completes a word.
  task automatic pack_byte(input logic [7:0] b);
    ts_word_t w;
    if (pack_fill == 2'd3) begin
      w.word = {pack_bytes, b};
      pkt_words = pkt_words + 6'd1;
      w.pkt_end = (pkt_words >= WORDS_PER_PACKET);
      if (w.pkt_end) pkt_words = '0;
      w.last = 1'b0;
      ts_words_q.push_back(w);
      words_made++;
      pack_bytes = '0;
      pack_fill = '0;
    end else begin
      pack_bytes = {pack_bytes[15:0], b};
      pack_fill = pack_fill + 2'd1;
    end
  endtask

  task automatic pack_stamp(input logic [32:0] t);
    pack_byte({4'b0, t[32:30], 1'b1});
    pack_byte(t[29:22]);
    pack_byte({t[21:15], 1'b1});
    pack_byte(t[14:7]);
    pack_byte({t[6:0], 1'b1});
  endtask

  task automatic packetize_byte();
    logic        first;
    logic        with_dts;
    int          hdr_len;
    int          room;
    int          pad;
    logic [3:0]  cc;
    logic [15:0] pes_len;
    first = 1'b0;
    words_made = 0;
    if (frame_left == '0) begin
      if (!in_frame_start || in_frame_length == '0) return;
      frame_left = in_frame_length;
      pkt_left = '0;
      first = 1'b1;
    end
    if (pkt_left == '0) begin
      with_dts = (in_pts != in_dts);
      hdr_len = with_dts ? 13 : 8;
      room = 184;
      cc = cont_cnt;
      cont_cnt = cont_cnt + 4'd1;
      pack_byte(sync_r);
      pack_byte({3'b0, pid_r[12:8]} | (first ? 8'h40 : 8'h00));
      pack_byte(pid_r[7:0]);
      if (first) room -= hdr_len + 6;
      pad = room - int'(frame_left);
      if (in_pcr_due) begin
        room -= 8;
        pad -= 8;
        if (pad < 0) pad = 0;
        pack_byte({4'h3, cc});
        pack_byte(8'(7 + pad));
        pack_byte(8'h10);
        pack_byte(in_pcr_base[32:25]);
        pack_byte(in_pcr_base[24:17]);
        pack_byte(in_pcr_base[16:9]);
        pack_byte(in_pcr_base[8:1]);
        pack_byte({in_pcr_base[0], 7'b0});
        pack_byte(8'h00);
        for (int i = 0; i < pad; i++) pack_byte(8'hFF);
        room -= pad;
      end else if (pad > 0) begin
        pack_byte({4'h3, cc});
        room -= pad;
        pack_byte(8'(pad - 1));
        for (int i = 1; i < pad; i++) pack_byte(8'h00);
      end else begin
        pack_byte({4'h1, cc});
      end
      if (first) begin
        pes_len = 16'(int'(frame_left) + hdr_len);
        if (zero_len_r) pes_len = '0;
        pack_byte(8'h00);
        pack_byte(8'h00);
        pack_byte(8'h01);
        pack_byte(stream_id_r);
        pack_byte(pes_len[15:8]);
        pack_byte(pes_len[7:0]);
        pack_byte(8'h80);
        pack_byte(with_dts ? 8'hC0 : 8'h80);
        pack_byte(8'(hdr_len - 3));
        if (with_dts) pack_stamp(in_pts);
        pack_stamp(in_dts);
      end
      pkt_left = 8'(room);
    end
    pack_byte(in_data_byte);
    pkt_left = pkt_left - 8'd1;
    frame_left = frame_left - 24'd1;
    if (words_made > 0) ts_words_q[$].last = 1'b1;
  endtask

  always @(posedge clk) begin
    ts_word_t exp_w;
    if (!rst_n) begin
      pid_r = PID_RESET;
      stream_id_r = STREAM_ID_RESET;
      sync_r = SYNC_BYTE_RESET;
      zero_len_r = 1'b1;
      frame_left = '0;
      pkt_left = '0;
      cont_cnt = '0;
      pack_bytes = '0;
      pack_fill = '0;
      pkt_words = '0;
      ts_words_q.delete();
    end else begin
      // Compare the output first: a word can never come from the same-edge input.
      if (out_valid && out_ready) begin
        if (ts_words_q.size() == 0) begin
          $display("%0t: unexpected word %h end %b last %b", $time, out_word,
                   out_packet_end, out_last);
          fail_count++;
        end else begin
          exp_w = ts_words_q.pop_front();
          if (exp_w.word !== out_word || exp_w.pkt_end !== out_packet_end ||
              exp_w.last !== out_last) begin
            $display("%0t: mismatch expected %h/%b/%b actual %h/%b/%b", $time,
                     exp_w.word, exp_w.pkt_end, exp_w.last, out_word,
                     out_packet_end, out_last);
            fail_count++;
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_PID:       pid_r = pwdata[12:0];
          REG_STREAM_ID: stream_id_r = pwdata[7:0];
          REG_SYNC_BYTE: sync_r = pwdata[7:0];
          REG_ZERO_LEN:  zero_len_r = pwdata[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) packetize_byte();
    end
    words_pending = ts_words_q.size();
  end

  initial begin
    fail_count = 0;
    words_pending = 0;
  end

endmodule

// File: bench/pes_to_ts_packetizer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pes_to_ts_packetizer_core_tb
// Feeds frames of payload bytes into the packetizer under several register
// settings and handshake patterns; a checker beside the block predicts and
// compares every output word. Prints the verdict at the end.
// ----------------------------------------------------------------------------
module pes_to_ts_packetizer_core_tb
  import pes2ts_pkg::*;
;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_frame_start;
  logic [23:0] in_frame_length;
  logic [32:0] in_pts;
  logic [32:0] in_dts;
  logic        in_pcr_due;
  logic [32:0] in_pcr_base;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_word;
  logic        out_packet_end;
  logic        out_last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int words_pending;
  int snd_idle_pct;
  int rcv_idle_pct;
  int hold_cycles;
  logic hold_req;
  logic hold_done;
  int byte_count;

  pes_to_ts_packetizer_core i_dut (.*);

  pes_to_ts_packetizer_core_chk i_chk (.*);

  always #2 clk = ~clk;

  // Hard limit on the whole run.
  initial begin
    #40000000;
    $display("FAIL pes_to_ts_packetizer_core");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request so the block
  // fills up and stalls its input.
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_cycles = 600;
      hold_done = 1'b1;
    end
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles--;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Offer one byte; hold valid and payload until the transfer.
  task automatic send_byte(input logic [7:0] d, input logic fs, input logic [23:0] flen,
                           input logic [32:0] pts, input logic [32:0] dts,
                           input logic pcr, input logic [32:0] pcr_b);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data_byte = d;
    in_frame_start = fs;
    in_frame_length = flen;
    in_pts = pts;
    in_dts = dts;
    in_pcr_due = pcr;
    in_pcr_base = pcr_b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
    byte_count++;
  endtask

  function automatic logic [32:0] rand33();
    return {1'($urandom_range(1)), $urandom};
  endfunction

  // One well-formed frame with random content; stray frame starts and
  // lengths inside the frame must be ignored by the block.
  task automatic send_frame(input int len);
    logic [32:0] pts;
    logic [32:0] dts;
    pts = rand33();
    dts = ($urandom_range(1) == 0) ? pts : rand33();
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom), (i == 0) ? 1'b1 : ($urandom_range(9) == 0),
                (i == 0) ? 24'(len) : 24'($urandom), pts, dts,
                ($urandom_range(3) == 0), rand33());
    end
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Drain: every predicted word out, then room for a packet header in flight.
  task automatic drain();
    do @(posedge clk); while (words_pending != 0);
    repeat (400) @(negedge clk);
  endtask

  // Frames are cut to the bytes left in the phase budget.
  task automatic random_phase(input int n_bytes);
    int stop_at;
    int r;
    int len;
    int room;
    int lens[8] = '{165, 169, 170, 171, 176, 177, 184, 185};
    stop_at = byte_count + n_bytes;
    while (byte_count < stop_at) begin
      r = $urandom_range(19);
      room = stop_at - byte_count;
      if (r == 0) begin
        // noise between frames: byte outside a frame, or a zero-length start
        send_byte(8'($urandom), 1'b0, 24'($urandom), rand33(), rand33(), 1'b1, rand33());
      end else if (r == 1) begin
        send_byte(8'($urandom), 1'b1, 24'd0, rand33(), rand33(), 1'b0, rand33());
      end else begin
        if (r < 12) begin
          len = $urandom_range(60, 1);
        end else if (r < 16) begin
          len = lens[$urandom_range(7)];
        end else begin
          len = $urandom_range(400, 100);
        end
        if (len > room) len = room;
        send_frame(len);
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = '0;
    in_frame_start = 1'b0;
    in_frame_length = '0;
    in_pts = '0;
    in_dts = '0;
    in_pcr_due = 1'b0;
    in_pcr_base = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_cycles = 0;
    hold_req = 1'b0;
    hold_done = 1'b0;
    byte_count = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: stray byte, zero length, extremes of the time stamps and PCR.
    send_byte(8'hFF, 1'b0, 24'hFFFFFF, '1, '1, 1'b1, '1);
    send_byte(8'h00, 1'b1, 24'd0, '1, '0, 1'b1, '1);
    send_byte(8'hA5, 1'b1, 24'd1, 33'd0, '1, 1'b1, '1);
    send_byte(8'h5A, 1'b1, 24'd1, '1, '1, 1'b0, '0);
    send_byte(8'h00, 1'b1, 24'd2, 33'h0AAAAAAAA, 33'h155555555, 1'b1, 33'h0AAAAAAAA);
    send_byte(8'hFF, 1'b1, 24'hFFFFFF, '0, '1, 1'b0, '0);
    send_byte(8'h3C, 1'b1, 24'd3, '0, '0, 1'b0, '0);
    send_byte(8'hC3, 1'b0, 24'd0, '0, '0, 1'b1, '0);
    send_byte(8'h81, 1'b0, 24'd0, '0, '0, 1'b0, '0);
    drain();

    // Extreme register values; sender rarely idles, receiver mostly stalls.
    cfg_write(REG_PID, 32'hFFFF_FFFF);
    cfg_write(REG_STREAM_ID, 32'h0000_00FF);
    cfg_write(REG_SYNC_BYTE, 32'h0000_0000);
    cfg_write(REG_ZERO_LEN, 32'h0000_0000);
    snd_idle_pct = 9;
    rcv_idle_pct = 87;
    random_phase(30);
    drain();

    cfg_write(REG_PID, 32'h0);
    cfg_write(REG_STREAM_ID, 32'h0);
    cfg_write(REG_SYNC_BYTE, 32'h47);
    cfg_write(REG_ZERO_LEN, 32'h1);
    snd_idle_pct = 87;
    rcv_idle_pct = 9;
    random_phase(30);
    drain();

    // One frame across two packets while the receiver holds off.
    cfg_write(REG_PID, $urandom);
    cfg_write(REG_STREAM_ID, $urandom);
    cfg_write(REG_SYNC_BYTE, $urandom);
    cfg_write(REG_ZERO_LEN, 32'h0);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_req = 1'b1;
    send_frame(185);
    drain();

    // Largest frame: PES length truncates to 16 bits; only a few bytes sent.
    send_byte(8'h11, 1'b1, 24'hFFFFFF, 33'h123456789, 33'h123456789, 1'b1, '1);
    for (int i = 0; i < 8; i++)
      send_byte(8'($urandom), 1'b0, '0, '0, '0, 1'b0, '0);

    do @(posedge clk); while (words_pending != 0);
    repeat (400) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS pes_to_ts_packetizer_core");
    end else begin
      $display("FAIL pes_to_ts_packetizer_core");
    end
    $finish;
  end

endmodule

// File: sim.f
design/pes2ts_pkg.sv
design/pes2ts_ctrl.sv
design/pes2ts_dp.sv
design/pes_to_ts_packetizer_core.sv
bench/pes_to_ts_packetizer_core_chk.sv
bench/pes_to_ts_packetizer_core_tb.sv
